// ===== rtl/core/sha256_pkg.sv =====
// Package for the streaming SHA-256 hasher: round constants, initial hash
// values, controller/datapath command and status types and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_W       = 61;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_byte;

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_byte PAD_BYTE  = 8'h80;
    localparam int unsigned LEN_POS = 56;

    // Byte source for a buffer write.
    typedef enum logic [1:0] {
        BSRC_DATA = 2'd0,
        BSRC_PAD  = 2'd1,
        BSRC_ZERO = 2'd2,
        BSRC_LEN  = 2'd3
    } t_bsrc;

    // Controller to datapath commands.
    typedef struct packed {
        logic       buf_we;      // write one byte at the fill pointer
        t_bsrc      buf_src;
        logic       len_inc;     // count one message byte
        logic       comp_start;  // begin compression of the buffer
        logic       digest_load; // copy chain value to the output shifter
        logic       digest_shift;
        logic       msg_clear;   // restore IV, length and fill pointer
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [5:0] fill;
        logic       comp_busy;
    } t_stat;

    function automatic t_word ror32(input t_word v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha256_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sha256_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sha256_datapath.sv =====
// Datapath of the SHA-256 hasher: byte buffer RAM, length counter, message
// schedule, round unit, chain value and digest shifter. Uses sha256_pkg.
`timescale 1ns / 1ps

module sha256_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha256_pkg::t_cmd  i_cmd,
    input  logic [7:0]        i_data_byte,
    output sha256_pkg::t_stat o_stat,
    output logic [31:0]       o_digest_word
);
    import sha256_pkg::*;

    logic [5:0]       r_fill;
    logic [LEN_W-1:0] r_len;
    t_word            r_h [8];
    t_word            r_s [8];
    t_word            r_w [16];
    t_word            r_dig [8];
    logic             r_busy;
    logic [6:0]       r_cnt;

    // Buffer and its ports.
    logic [5:0] buf_raddr;
    t_byte      buf_rdata;
    t_byte      buf_wdata;
    logic [63:0] bit_len;
    logic [2:0]  len_idx;

    assign bit_len = {r_len, 3'b000};
    assign len_idx = r_fill[2:0];

    always_comb begin
        case (i_cmd.buf_src)
            BSRC_DATA: buf_wdata = i_data_byte;
            BSRC_PAD:  buf_wdata = PAD_BYTE;
            BSRC_ZERO: buf_wdata = '0;
            BSRC_LEN:  buf_wdata = bit_len[8*(7-len_idx) +: 8];
            default:   buf_wdata = '0;
        endcase
    end

    sha256_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.buf_we),
        .i_waddr (r_fill),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Compression sequencing: r_cnt 0..63 addresses the bytes (read data is registered),
    // every fourth returned byte completes a word; a round runs as each of the first 16
    // words completes, then one per cycle for rounds 16..63.
    // Phase A (r_cnt 0..64): load 16 words with rounds interleaved.
    // For simplicity rounds run as words become available.
    logic [6:0] r_round;
    logic [1:0] r_bpos;
    t_word      r_wacc;
    logic       r_load;   // loading bytes phase
    logic       r_fin;    // final add pending

    assign buf_raddr = r_cnt[5:0];

    // Schedule word for the next round.
    t_word s0, s1, w_new, w_cur, t1, t2, e, a;
    logic  round_go;

    always_comb begin
        s0    = ror32(r_w[1], 7) ^ ror32(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = ror32(r_w[14], 17) ^ ror32(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = (r_round < 7'd16) ? {r_wacc[23:0], buf_rdata} : w_new;
        e     = r_s[4];
        a     = r_s[0];
        t1    = r_s[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
              + ((e & r_s[5]) ^ (~e & r_s[6])) + ROUND_K[r_round[5:0]] + w_cur;
        t2    = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
              + ((a & r_s[1]) ^ (a & r_s[2]) ^ (r_s[1] & r_s[2]));
        round_go = r_busy && !r_fin &&
                   ((r_round < 7'd16) ? (r_load && r_cnt != 7'd0 && r_bpos == 2'd3)
                                      : 1'b1);
    end

    // Control registers of the compression unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_round <= '0;
            r_bpos  <= '0;
            r_load  <= 1'b0;
            r_fin   <= 1'b0;
        end else if (i_cmd.comp_start) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_round <= '0;
            r_bpos  <= '0;
            r_load  <= 1'b1;
            r_fin   <= 1'b0;
        end else if (r_busy) begin
            if (r_load) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt != 7'd0) begin
                    r_bpos <= r_bpos + 2'd1;
                end
                if (r_cnt == 7'd64) begin
                    r_load <= 1'b0;
                end
            end
            if (round_go) begin
                r_round <= r_round + 7'd1;
                if (r_round == 7'd63) begin
                    r_fin <= 1'b1;
                end
            end
            if (r_fin) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end
        end
    end

    // Word assembly, schedule window and working variables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            for (int i = 0; i < 8; i++) begin
                r_s[i] <= r_h[i];
            end
        end else if (r_busy) begin
            if (r_load && r_cnt != 7'd0) begin
                r_wacc <= {r_wacc[23:0], buf_rdata};
            end
            if (round_go) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_cur;
                r_s[7] <= r_s[6];
                r_s[6] <= r_s[5];
                r_s[5] <= e;
                r_s[4] <= r_s[3] + t1;
                r_s[3] <= r_s[2];
                r_s[2] <= r_s[1];
                r_s[1] <= a;
                r_s[0] <= t1 + t2;
            end
        end
    end

    // Chain value: final add after 64 rounds, restore on reset or msg_clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.msg_clear) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_H[i];
            end
        end else if (r_fin) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_s[i];
            end
        end
    end

    // Fill pointer and message length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.msg_clear) begin
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.buf_we) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.len_inc) begin
                r_len <= r_len + {{(LEN_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // Digest shifter, word 0 first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.digest_load) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_h[i];
            end
        end else if (i_cmd.digest_shift) begin
            for (int i = 0; i < 7; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    assign o_stat.fill      = r_fill;
    assign o_stat.comp_busy = r_busy;
    assign o_digest_word    = r_dig[0];

endmodule

// ===== rtl/core/sha256_ctrl.sv =====
// Controller of the SHA-256 hasher: input handshake, padding sequence,
// compression start and digest output sequencing. Uses sha256_pkg.
`timescale 1ns / 1ps

module sha256_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_word_index,
    output logic              o_last_word,
    input  sha256_pkg::t_stat i_stat,
    output sha256_pkg::t_cmd  o_cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ABS_WAIT, S_PAD, S_PAD_WAIT, S_LEN, S_FIN_WAIT, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic       r_started, n_started;
    logic       in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_started = 1'b0;
        o_cmd     = '0;
        o_cmd.buf_src = BSRC_DATA;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.buf_we = 1'b1;
                    if (!i_command) begin
                        o_cmd.len_inc = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            n_state   = S_ABS_WAIT;
                            n_started = 1'b1;
                        end
                    end else begin
                        o_cmd.buf_src = BSRC_PAD;
                        if (i_stat.fill == 6'd63) begin
                            n_state   = S_PAD_WAIT;
                            n_started = 1'b1;
                        end else if (i_stat.fill >= 6'd56) begin
                            n_state = S_PAD;
                        end else begin
                            n_state = S_LEN;
                        end
                    end
                end
            end
            S_ABS_WAIT: begin
                if (!r_started && !i_stat.comp_busy) n_state = S_IDLE;
            end
            S_PAD: begin
                o_cmd.buf_we  = 1'b1;
                o_cmd.buf_src = BSRC_ZERO;
                if (i_stat.fill == 6'd63) begin
                    n_state   = S_PAD_WAIT;
                    n_started = 1'b1;
                end
            end
            S_PAD_WAIT: begin
                if (!r_started && !i_stat.comp_busy) n_state = S_LEN;
            end
            S_LEN: begin
                o_cmd.buf_we  = 1'b1;
                o_cmd.buf_src = (i_stat.fill < 6'(LEN_POS)) ? BSRC_ZERO : BSRC_LEN;
                if (i_stat.fill == 6'd63) begin
                    n_state   = S_FIN_WAIT;
                    n_started = 1'b1;
                end
            end
            S_FIN_WAIT: begin
                if (!r_started && !i_stat.comp_busy) begin
                    o_cmd.digest_load = 1'b1;
                    o_cmd.msg_clear   = 1'b1;
                    n_valid = 1'b1;
                    n_idx   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    o_cmd.digest_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_valid = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.comp_start = n_started;
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_valid   <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_valid   <= n_valid;
            r_started <= n_started;
        end
    end

    assign o_valid      = r_valid;
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

endmodule

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// Top level of the streaming SHA-256 hasher.
// Instantiates sha256_ctrl and sha256_datapath; uses sha256_pkg.
`timescale 1ns / 1ps
// Usage:
// The input channel (i_valid, o_stall) carries one word per item: i_command
// 0 absorbs i_data_byte, 1 finishes the message. An absorb does not stall,
// except the byte that fills a 64-byte block, which stalls the input while
// the block is compressed (byte reads from the buffer RAM that carry the
// first 16 rounds, 48 further rounds of the single round unit, one
// chain-value add and the release of the input).
// A finish writes the padding one byte per cycle, pausing while a first
// block is compressed, and runs one or two compressions: the first digest
// word follows one compression when the padding fits the current block, and
// two when a second block is needed. The digest then leaves on
// the output channel (o_valid, i_stall) as eight words at up to one per
// cycle, index 0 first, o_last_word on the eighth. The input stays stalled
// until the last digest word is taken; a stalled digest word holds.
// Synchronous active-low reset restores the initial hash value, clears the
// byte count and drops o_valid; the buffer RAM needs no clearing.

module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    sha256_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_stat        (stat),
        .o_digest_word (o_digest_word)
    );

endmodule

// ===== rtl/core/sha256_checker.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level.
// No dependencies.
`timescale 1ns / 1ps

module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // The last marker sits on index seven only.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last marker mismatch");

    // A taken word is followed by the next index.
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=>
        (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest index skipped");

    // No input is taken while a digest is pending.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted during digest output");

    // A stalled word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)))
        else $error("stalled word changed");

endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming SHA-256 hasher top level.
// Depends on sha256_pkg (round constants, initial hash) and sha256_stream_hasher_top.
`timescale 1ns / 1ps

module tb;
    import sha256_pkg::*;

    localparam int unsigned RAND_ITEMS = 230;
    localparam int unsigned HOLD_CYCLES = 1500;

    typedef enum logic {CMD_ABSORB = 1'b0, CMD_FINISH = 1'b1} t_command;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // One row of the directed stimulus; digest is used only where known is set.
    typedef struct {
        t_command    command;
        logic [7:0]  data;
        bit          known;
        logic [255:0] digest;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    // Hashing state mirrored from the block.
    t_word        chain [8];
    t_byte        block_buf [64];
    int unsigned  fill_bytes;
    logic [60:0]  msg_bytes;

    t_digest_word digest_pending [$];
    int unsigned  error_count;
    int unsigned  sender_idle_pct;
    int unsigned  stall_pct;
    bit           hold_request;
    t_row         rows [$];

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic t_word rotr(input t_word v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of the block buffer into the chain value.
    function automatic void compress_block();
        t_word w [64];
        t_word s [8];
        t_word t1;
        t_word t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) s[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += s[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
        fill_bytes = 0;
        msg_bytes  = '0;
    endfunction

    // Updates the mirrored state for one accepted word and queues any digest words.
    function automatic void hash_word(input t_row r);
        logic [63:0] bit_len;
        if (r.command == CMD_ABSORB) begin
            block_buf[fill_bytes] = r.data;
            msg_bytes = msg_bytes + 1'b1;
            fill_bytes++;
            if (fill_bytes == 64) begin
                compress_block();
                fill_bytes = 0;
            end
        end else begin
            bit_len = {msg_bytes, 3'b000};
            block_buf[fill_bytes++] = PAD_BYTE;
            if (fill_bytes > LEN_POS) begin
                while (fill_bytes < 64) block_buf[fill_bytes++] = 8'h00;
                compress_block();
                fill_bytes = 0;
            end
            while (fill_bytes < LEN_POS) block_buf[fill_bytes++] = 8'h00;
            for (int i = 0; i < 8; i++) block_buf[LEN_POS+i] = bit_len[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                digest_pending.push_back('{
                    word:  r.known ? r.digest[255-32*i -: 32] : chain[i],
                    index: 3'(i),
                    last:  (i == 7)});
            end
            restart_message();
        end
    endfunction

    // Offers one word and waits for it to be taken.
    task automatic send_word(input t_row r);
        bit taken;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= r.command;
        i_data_byte <= r.data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            if (taken) hash_word(r);
            @(posedge i_clk);
        end
    endtask

    // Receiver: random stall, with one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Digest checker; the values at the falling edge are those taken at the next rising edge.
    always @(negedge i_clk) begin
        t_digest_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_pending.size() == 0) begin
                report("unexpected digest word", o_digest_word, 32'h0);
            end else begin
                want = digest_pending.pop_front();
                if (o_digest_word !== want.word) report("digest_word", o_digest_word, want.word);
                if (o_word_index !== want.index) report("word_index", o_word_index, want.index);
                if (o_last_word !== want.last) report("last_word", o_last_word, want.last);
            end
        end
    end

    // Stimulus.
    initial begin
        int unsigned sent;
        int unsigned msg_count;
        int unsigned msg_len;
        int unsigned edge_lens [9];
        t_row r;
        edge_lens   = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = CMD_ABSORB;
        i_data_byte = 8'h00;
        error_count = 0;
        sender_idle_pct = 0;
        stall_pct   = 0;
        hold_request = 1'b0;
        restart_message();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, "abc", byte extremes, finish straight after finish.
        rows.push_back('{CMD_FINISH, 8'h00, 1'b1,
            256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855});
        rows.push_back('{CMD_ABSORB, 8'h61, 1'b0, '0});
        rows.push_back('{CMD_ABSORB, 8'h62, 1'b0, '0});
        rows.push_back('{CMD_ABSORB, 8'h63, 1'b0, '0});
        rows.push_back('{CMD_FINISH, 8'hff, 1'b1,
            256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad});
        rows.push_back('{CMD_ABSORB, 8'h00, 1'b0, '0});
        rows.push_back('{CMD_ABSORB, 8'hff, 1'b0, '0});
        rows.push_back('{CMD_FINISH, 8'h00, 1'b0, '0});
        rows.push_back('{CMD_FINISH, 8'h55, 1'b1,
            256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855});
        foreach (rows[i]) send_word(rows[i]);

        // Random messages, lengths biased to the padding boundaries.
        sent = 0;
        msg_count = 0;
        while (sent < RAND_ITEMS) begin
            case (msg_count % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 79; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 79; end
                default: begin sender_idle_pct = 18; stall_pct = 18; end
            endcase
            if (msg_count == 3) hold_request = 1'b1;
            msg_len = ($urandom_range(0, 2) == 0) ? edge_lens[$urandom_range(0, 8)]
                                                  : $urandom_range(0, 24);
            // The last message is cut so that the item count stays near the target.
            if (msg_len + 1 > RAND_ITEMS - sent) msg_len = RAND_ITEMS - sent - 1;
            r.known  = 1'b0;
            r.digest = '0;
            for (int i = 0; i < msg_len; i++) begin
                r.command = CMD_ABSORB;
                r.data    = 8'($urandom_range(0, 255));
                send_word(r);
            end
            r.command = CMD_FINISH;
            r.data    = 8'($urandom_range(0, 255));
            send_word(r);
            sent += msg_len + 1;
            msg_count++;
        end
        i_valid <= 1'b0;

        while (digest_pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
